[rtl/lfr_pkg.sv]
package lfr_pkg;

  localparam logic [7:0] START_BYTE = 8'h7E;
  localparam logic [7:0] END_BYTE   = 8'hE7;

  localparam logic [7:0]  LABEL_RESET   = 8'd14;
  localparam logic [15:0] MAX_LEN_RESET = 16'd600;
  localparam logic [15:0] DELIVER_RESET = 16'd1;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXPECTED_LABEL = 2'd0,
    CFG_MAX_LENGTH     = 2'd1,
    CFG_DELIVER_COUNT  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_GOOD     = 2'd1,
    KIND_TOO_LONG = 2'd2,
    KIND_BAD_END  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0]  expected_label;
    logic [15:0] max_length;
    logic [15:0] deliver_count;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [15:0] frame_length;
  } result_t;

endpackage

[rtl/lfr_cfg.sv]
module lfr_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfr_pkg::CFG_DATA_W-1:0] cfg_data,
  output lfr_pkg::cfg_t                 cfg
);
  import lfr_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  // Writes to an index past the register list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_label <= LABEL_RESET;
      cfg_r.max_length     <= MAX_LEN_RESET;
      cfg_r.deliver_count  <= DELIVER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_EXPECTED_LABEL: cfg_r.expected_label <= cfg_data[7:0];
        CFG_MAX_LENGTH:     cfg_r.max_length     <= cfg_data;
        CFG_DELIVER_COUNT:  cfg_r.deliver_count  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[rtl/lfr_parse.sv]
module lfr_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic [7:0]       rx_byte,
  input  lfr_pkg::cfg_t    cfg,
  output logic             emit,
  output lfr_pkg::result_t result
);
  import lfr_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LABEL   = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_END     = 3'd5
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] length_r, length_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] len_full;
  logic [16:0] idx_inc;

  assign len_full = {rx_byte, length_r[7:0]};
  assign idx_inc  = {1'b0, count_r} + 17'd1;

  always_comb begin
    phase_nxt           = phase_r;
    length_nxt          = length_r;
    count_nxt           = count_r;
    emit                = 1'b0;
    result.kind         = KIND_PAYLOAD;
    result.payload_byte = 8'h00;
    result.byte_index   = 16'h0000;
    result.frame_length = length_r;
    unique case (phase_r)
      PH_LABEL: begin
        // The label compare wins, so a label equal to the start byte works.
        if (rx_byte == cfg.expected_label) begin
          phase_nxt = PH_LEN_LO;
        end else if (rx_byte == START_BYTE) begin
          phase_nxt = PH_LABEL;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_LEN_LO: begin
        length_nxt = {8'h00, rx_byte};
        phase_nxt  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_nxt = len_full;
        count_nxt  = 16'h0000;
        if (len_full > cfg.max_length) begin
          phase_nxt           = PH_HUNT;
          emit                = 1'b1;
          result.kind         = KIND_TOO_LONG;
          result.frame_length = len_full;
        end else if (len_full == 16'h0000) begin
          phase_nxt = PH_END;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (count_r < cfg.deliver_count) begin
          emit                = 1'b1;
          result.payload_byte = rx_byte;
          result.byte_index   = count_r;
        end
        count_nxt = idx_inc[15:0];
        if (idx_inc >= {1'b0, length_r}) begin
          phase_nxt = PH_END;
        end
      end
      PH_END: begin
        phase_nxt   = PH_HUNT;
        emit        = 1'b1;
        result.kind = (rx_byte == END_BYTE) ? KIND_GOOD : KIND_BAD_END;
      end
      default: begin
        // Unused codes behave like hunting.
        phase_nxt = (rx_byte == START_BYTE) ? PH_LABEL : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      length_r <= 16'h0000;
      count_r  <= 16'h0000;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      length_r <= length_nxt;
      count_r  <= count_nxt;
    end
  end

  a_too_long_rehunts: assert property (@(posedge clk) disable iff (!rst_n)
    advance && phase_r == PH_LEN_HI && emit |=> phase_r == PH_HUNT)
    else $error("length error did not return to hunting");

  a_end_reports: assert property (@(posedge clk) disable iff (!rst_n)
    advance && phase_r == PH_END |-> emit && result.kind != KIND_PAYLOAD)
    else $error("end byte produced no status");

  a_payload_exit: assert property (@(posedge clk) disable iff (!rst_n)
    advance && phase_r == PH_PAYLOAD |=> phase_r == PH_PAYLOAD || phase_r == PH_END)
    else $error("payload phase left for a wrong phase");

  a_status_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    emit && result.kind != KIND_PAYLOAD |->
      result.payload_byte == 8'h00 && result.byte_index == 16'h0000 && phase_nxt == PH_HUNT)
    else $error("status request carries payload data or does not rehunt");

endmodule

[rtl/labelled_frame_receiver_core.sv]
// Deframer for start / label / length / payload / end frames, one received byte
// per request. Each byte is registered on entry, decoded by a phase machine
// and its result, if any, is registered on the way out, so a result reaches
// the outputs through the input register and then the output register. A byte
// can be taken every cycle unless a held result waits on out_ready. in_ready follows
// out_ready combinationally when both register stages are full. Payload bytes
// are streamed before the frame is checked, so the consumer must discard them
// when the frame closes with a length error or a bad end byte.
module labelled_frame_receiver_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_kind,
  output logic [7:0]                     out_payload_byte,
  output logic [15:0]                    out_byte_index,
  output logic [15:0]                    out_frame_length,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lfr_pkg::*;

  cfg_t    cfg;
  logic    s1_valid_r;
  logic [7:0] s1_byte_r;
  logic    out_valid_r;
  result_t out_r;
  logic    advance;
  logic    emit;
  result_t result;

  lfr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // A byte leaves the input register only when the result slot is free,
  // even if it produces no result.
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  lfr_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .rx_byte (s1_byte_r),
    .cfg     (cfg),
    .emit    (emit),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_r.kind;
  assign out_payload_byte = out_r.payload_byte;
  assign out_byte_index   = out_r.byte_index;
  assign out_frame_length = out_r.frame_length;

endmodule
